// ----- design/smf_pkg.sv -----
// Shared constants and types of the separable max filter.
// Used by every module of the block but smf_ram; depends on nothing.
package smf_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_RADIUS  = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS  = $clog2(RING_ROWS);
    localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int DIM_BITS   = 10;
    localparam int CFG_BITS   = 10;
    localparam int CNT_BITS   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RING_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_BITS  = SLOT_BITS + X_BITS;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS       = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [RAD_BITS-1:0] r;
        logic [CNT_BITS-1:0] delay;
        logic [CNT_BITS-1:0] total;
    } frame_cfg_t;

    typedef struct packed {
        logic                busy;
        logic [CNT_BITS-1:0] pixels_in;
        logic [CNT_BITS-1:0] pixels_out;
    } eng_stat_t;

endpackage

// ----- design/smf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/smf_cfg.sv -----
// Configuration registers with clamping and derived frame constants.
// Depends on smf_pkg.
module smf_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [smf_pkg::CFG_BITS-1:0] cfg_wdata,
    output smf_pkg::frame_cfg_t          fcfg,
    output logic                         clear
);

    localparam int DB = smf_pkg::DIM_BITS;
    localparam int RB = smf_pkg::RAD_BITS;
    localparam int CB = smf_pkg::CNT_BITS;

    logic [DB-1:0] w_reg, h_reg;
    logic [RB-1:0] r_reg;
    logic [DB-1:0] wv, hv, rx, ry, re;
    logic [RB-1:0] rv;

    always_comb begin
        wv = cfg_wdata[DB-1:0];
        hv = cfg_wdata[DB-1:0];
        rv = cfg_wdata[RB-1:0];
        re = DB'(r_reg);
        rx = (re < w_reg - 1'b1) ? re : w_reg - 1'b1;
        ry = (re < h_reg - 1'b1) ? re : h_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= DB'(smf_pkg::MAX_WIDTH);
            h_reg     <= DB'(smf_pkg::MAX_HEIGHT);
            r_reg     <= RB'(1);
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    smf_pkg::CFG_FRAME_WIDTH: begin
                        if (wv == '0) w_reg <= DB'(1);
                        else if (wv > DB'(smf_pkg::MAX_WIDTH)) w_reg <= DB'(smf_pkg::MAX_WIDTH);
                        else w_reg <= wv;
                    end
                    smf_pkg::CFG_FRAME_HEIGHT: begin
                        if (hv == '0) h_reg <= DB'(1);
                        else if (hv > DB'(smf_pkg::MAX_HEIGHT)) h_reg <= DB'(smf_pkg::MAX_HEIGHT);
                        else h_reg <= hv;
                    end
                    smf_pkg::CFG_RADIUS: begin
                        if (rv == '0) r_reg <= RB'(1);
                        else if (rv > RB'(smf_pkg::MAX_RADIUS)) r_reg <= RB'(smf_pkg::MAX_RADIUS);
                        else r_reg <= rv;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign clear = cfg_we && (cfg_addr == smf_pkg::CFG_FRAME_WIDTH ||
                              cfg_addr == smf_pkg::CFG_FRAME_HEIGHT ||
                              cfg_addr == smf_pkg::CFG_RADIUS);

    assign fcfg.w     = w_reg;
    assign fcfg.h     = h_reg;
    assign fcfg.r     = r_reg;
    assign fcfg.delay = CB'(ry) * CB'(w_reg) + CB'(rx);
    assign fcfg.total = CB'(w_reg) * CB'(h_reg);

endmodule

// ----- design/smf_engine.sv -----
// Sequencer of the filter: writes samples to the row ring, forms row maxima
// into a second ring and takes the column maximum. Depends on smf_pkg, smf_ram.
module smf_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  smf_pkg::frame_cfg_t             fcfg,
    input  logic                            clear,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_func,
    input  logic [smf_pkg::SAMPLE_BITS-1:0] in_pixel,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [smf_pkg::SAMPLE_BITS-1:0] res_data,
    output logic                            res_last,
    output smf_pkg::eng_stat_t              stat
);

    localparam int XB = smf_pkg::X_BITS;
    localparam int SB = smf_pkg::SLOT_BITS;
    localparam int RB = smf_pkg::RAD_BITS;
    localparam int DB = smf_pkg::DIM_BITS;
    localparam int CB = smf_pkg::CNT_BITS;
    localparam int DW = smf_pkg::SAMPLE_BITS;
    localparam int AB = smf_pkg::ADDR_BITS;
    localparam logic [SB:0] RING = (SB+1)'(smf_pkg::RING_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_HREAD, ST_HLAST, ST_VREAD, ST_VLAST, ST_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CB-1:0] pin_reg, pin_next, pout_reg, pout_next;
    logic [XB-1:0] xin_reg, xin_next, ox_reg, ox_next;
    logic [SB-1:0] sin_reg, sin_next, sout_reg, sout_next;
    logic [DB-1:0] oy_reg, oy_next;
    logic [XB-1:0] x0_reg, x0_next, x1_reg, x1_next, xr_reg, xr_next;
    logic [SB-1:0] hslot_reg, hslot_next, vslot_reg, vslot_next;
    logic [RB-1:0] hcnt_reg, hcnt_next;
    logic [RB:0]   vcnt_reg, vcnt_next;
    logic [DW-1:0] acc_reg, acc_next, res_reg, res_next;
    logic          pend_reg, pend_next;

    logic          ring_we, hring_we;
    logic [DW-1:0] ring_rdata, hring_rdata, hmax, vmax;

    logic [DB-1:0] oxe, re, x0w, x1w, y0w, y1w, d0w, d1w;
    logic [SB:0]   y0s_sum, y1s_sum;
    logic          emit_px, emit_dr, px_ok, frame_end;

    smf_ram #(.WIDTH(DW), .DEPTH(smf_pkg::RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr ({sin_reg, xin_reg}),
        .wdata (in_pixel),
        .raddr (AB'({hslot_reg, xr_reg})),
        .rdata (ring_rdata)
    );

    smf_ram #(.WIDTH(DW), .DEPTH(smf_pkg::RING_DEPTH)) u_hring (
        .aclk  (aclk),
        .we    (hring_we),
        .waddr ({hslot_reg, ox_reg}),
        .wdata (hmax),
        .raddr ({vslot_reg, ox_reg}),
        .rdata (hring_rdata)
    );

    always_comb begin
        oxe = DB'(ox_reg);
        re  = DB'(fcfg.r);
        x0w = (oxe > re) ? oxe - re : '0;
        x1w = (oxe + re < fcfg.w - 1'b1) ? oxe + re : fcfg.w - 1'b1;
        y0w = (oy_reg > re) ? oy_reg - re : '0;
        y1w = (oy_reg + re < fcfg.h - 1'b1) ? oy_reg + re : fcfg.h - 1'b1;
        d0w = oy_reg - y0w;
        d1w = y1w - oy_reg;
        y0s_sum = ({1'b0, sout_reg} >= (SB+1)'(d0w)) ? {1'b0, sout_reg} - (SB+1)'(d0w)
                                                      : {1'b0, sout_reg} + RING - (SB+1)'(d0w);
        y1s_sum = {1'b0, sout_reg} + (SB+1)'(d1w);
        if (y1s_sum >= RING) y1s_sum = y1s_sum - RING;

        hmax = (ring_rdata > acc_reg) ? ring_rdata : acc_reg;
        vmax = (hring_rdata > acc_reg) ? hring_rdata : acc_reg;

        px_ok   = pin_reg < fcfg.total;
        emit_px = px_ok && (pout_reg < fcfg.total) &&
                  ({1'b0, pin_reg} >= {1'b0, pout_reg} + {1'b0, fcfg.delay});
        emit_dr = !px_ok && (pout_reg < fcfg.total);
        frame_end = (pout_reg + 1'b1) == fcfg.total;
    end

    always_comb begin
        state_next = state_reg;
        pin_next   = pin_reg;
        pout_next  = pout_reg;
        xin_next   = xin_reg;
        sin_next   = sin_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        sout_next  = sout_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        xr_next    = xr_reg;
        hslot_next = hslot_reg;
        vslot_next = vslot_reg;
        hcnt_next  = hcnt_reg;
        vcnt_next  = vcnt_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        pend_next  = pend_reg;
        ring_we    = 1'b0;
        hring_we   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_func == smf_pkg::FUNC_PIXEL) begin
                        if (px_ok) begin
                            ring_we  = 1'b1;
                            pin_next = pin_reg + 1'b1;
                            if (DB'(xin_reg) == fcfg.w - 1'b1) begin
                                xin_next = '0;
                                sin_next = ({1'b0, sin_reg} == RING - 1'b1) ? '0 : sin_reg + 1'b1;
                            end else begin
                                xin_next = xin_reg + 1'b1;
                            end
                        end
                        if (emit_px) state_next = ST_SETUP;
                    end else if (emit_dr) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                x0_next   = XB'(x0w);
                x1_next   = XB'(x1w);
                xr_next   = XB'(x0w);
                vslot_next = SB'(y0s_sum);
                vcnt_next = (RB+1)'(y1w - y0w);
                acc_next  = '0;
                pend_next = 1'b0;
                if (oy_reg == '0) begin
                    hslot_next = '0;
                    hcnt_next  = RB'(y1w);
                    state_next = ST_HREAD;
                end else if (oy_reg + re <= fcfg.h - 1'b1) begin
                    hslot_next = SB'(y1s_sum);
                    hcnt_next  = '0;
                    state_next = ST_HREAD;
                end else begin
                    state_next = ST_VREAD;
                end
            end
            ST_HREAD: begin
                if (pend_reg) acc_next = hmax;
                pend_next = 1'b1;
                if (xr_reg == x1_reg) state_next = ST_HLAST;
                else xr_next = xr_reg + 1'b1;
            end
            ST_HLAST: begin
                hring_we  = 1'b1;
                acc_next  = '0;
                pend_next = 1'b0;
                if (hcnt_reg == '0) begin
                    state_next = ST_VREAD;
                end else begin
                    hcnt_next  = hcnt_reg - 1'b1;
                    hslot_next = ({1'b0, hslot_reg} == RING - 1'b1) ? '0 : hslot_reg + 1'b1;
                    xr_next    = x0_reg;
                    state_next = ST_HREAD;
                end
            end
            ST_VREAD: begin
                if (pend_reg) acc_next = vmax;
                pend_next = 1'b1;
                if (vcnt_reg == '0) begin
                    state_next = ST_VLAST;
                end else begin
                    vcnt_next  = vcnt_reg - 1'b1;
                    vslot_next = ({1'b0, vslot_reg} == RING - 1'b1) ? '0 : vslot_reg + 1'b1;
                end
            end
            ST_VLAST: begin
                res_next   = vmax;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                    if (frame_end) begin
                        pin_next  = '0;
                        pout_next = '0;
                        xin_next  = '0;
                        sin_next  = '0;
                        ox_next   = '0;
                        oy_next   = '0;
                        sout_next = '0;
                    end else begin
                        pout_next = pout_reg + 1'b1;
                        if (oxe == fcfg.w - 1'b1) begin
                            ox_next   = '0;
                            oy_next   = oy_reg + 1'b1;
                            sout_next = ({1'b0, sout_reg} == RING - 1'b1) ? '0 : sout_reg + 1'b1;
                        end else begin
                            ox_next = ox_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (clear) begin
            pin_next  = '0;
            pout_next = '0;
            xin_next  = '0;
            sin_next  = '0;
            ox_next   = '0;
            oy_next   = '0;
            sout_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pin_reg   <= '0;
            pout_reg  <= '0;
            xin_reg   <= '0;
            sin_reg   <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            sout_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pin_reg   <= pin_next;
            pout_reg  <= pout_next;
            xin_reg   <= xin_next;
            sin_reg   <= sin_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            sout_reg  <= sout_next;
            pend_reg  <= pend_next;
        end
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        xr_reg    <= xr_next;
        hslot_reg <= hslot_next;
        vslot_reg <= vslot_next;
        hcnt_reg  <= hcnt_next;
        vcnt_reg  <= vcnt_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_OUT);
    assign res_data        = res_reg;
    assign res_last        = frame_end;
    assign stat.busy       = (state_reg != ST_IDLE);
    assign stat.pixels_in  = pin_reg;
    assign stat.pixels_out = pout_reg;

endmodule

// ----- design/separable_max_filter_2d_core.sv -----
// Top level of the streaming square-window max filter (grayscale dilation).
// Depends on smf_pkg, smf_cfg, smf_engine.
//
// Input requests carry one sample (s_tdata) per raster pixel, or a drain
// request (s_tuser = 1) that releases one pending output after frame end.
// Output k leaves on the m_ side once input k + ry*w + rx has arrived, with
// the maximum over the clipped window and m_tlast on the last pixel.
// Each output is computed by reading line memory one word per cycle:
// the row maximum for a new row is formed over the ring of samples and
// the column maximum over the ring of row maxima, with further states to
// take the request, set up and hand off; on the first output row, all
// rows of the window get their row maxima.
// A request that releases no output leaves s_tready high.
// s_tready is low while an output is being computed or waits to be handed
// off; a stalled receiver holds one result in the output register while the next request is taken.
// Reset (aresetn low, synchronous) restores width 512, height 512, radius 1
// and clears the frame counters; line memory needs no clearing pass.
// A configuration write to width, height or radius starts a new frame.
module separable_max_filter_2d_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smf_pkg::SAMPLE_BITS-1:0] s_tdata,   // [15:0] pixel_value
    input  logic                            s_tuser,   // [0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smf_pkg::SAMPLE_BITS-1:0] m_tdata,   // [15:0] max_value
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [smf_pkg::CFG_BITS-1:0]    cfg_wdata
);

    smf_pkg::frame_cfg_t fcfg;
    smf_pkg::eng_stat_t  stat;
    logic                clear, res_valid, res_ready, res_last;
    logic [smf_pkg::SAMPLE_BITS-1:0] res_data;
    logic                m_tvalid_reg, m_tlast_reg;
    logic [smf_pkg::SAMPLE_BITS-1:0] m_tdata_reg;

    smf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fcfg      (fcfg),
        .clear     (clear)
    );

    smf_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fcfg      (fcfg),
        .clear     (clear),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_pixel  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .res_last  (res_last),
        .stat      (stat)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_tdata_reg <= res_data;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_out_behind_in: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pixels_out <= stat.pixels_in)
        else $error("output count ran ahead of input count");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready && res_last && !clear |=>
            stat.pixels_out == '0 && stat.pixels_in == '0)
        else $error("counters did not return to zero after the last output");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_tready)
        else $error("request taken while an output is in progress");

    a_result_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> stat.pixels_out < fcfg.total)
        else $error("result offered beyond the end of the frame");
`endif

endmodule

// ----- test/tb_separable_max_filter_2d_core.sv -----
// Testbench for separable_max_filter_2d_core: random and directed frames
// checked against a behavioral window-max predictor. Depends on smf_pkg and the DUT.
`timescale 1ns / 1ps
module tb_separable_max_filter_2d_core;

    localparam int DW        = smf_pkg::SAMPLE_BITS;
    localparam int CB        = smf_pkg::CFG_BITS;
    localparam int RROWS     = smf_pkg::RING_ROWS;
    localparam int MW        = smf_pkg::MAX_WIDTH;

    typedef struct packed {
        logic              func;
        logic [DW-1:0]     pix;
    } pix_req_t;

    typedef struct packed {
        logic [DW-1:0] mx;
        logic          lst;
    } max_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [CB-1:0] cfg_wdata = '0;

    separable_max_filter_2d_core dut (.*);

    pix_req_t pending_reqs[$];
    max_out_t expected_max[$];
    int errors = 0;
    int accepted = 0;
    int pushed = 0;
    logic hold = 1'b0;

    // predictor state
    logic [DW-1:0] ring [smf_pkg::RING_DEPTH];
    int unsigned cnt_in, cnt_out;
    int unsigned reg_w = 512, reg_h = 512, reg_r = 1;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned pred_delay();
        int unsigned w, h, r, rx, ry;
        w = clampu(reg_w, 1, smf_pkg::MAX_WIDTH);
        h = clampu(reg_h, 1, smf_pkg::MAX_HEIGHT);
        r = clampu(reg_r, 1, smf_pkg::MAX_RADIUS);
        rx = r < w - 1 ? r : w - 1;
        ry = r < h - 1 ? r : h - 1;
        return ry * w + rx;
    endfunction

    task automatic emit_max(int unsigned w, int unsigned h, int unsigned r);
        int unsigned ox, oy, x0, x1, y0, y1;
        logic [DW-1:0] m;
        max_out_t e;
        ox = cnt_out % w;
        oy = cnt_out / w;
        x0 = ox > r ? ox - r : 0;
        x1 = (ox + r < w - 1) ? ox + r : w - 1;
        y0 = oy > r ? oy - r : 0;
        y1 = (oy + r < h - 1) ? oy + r : h - 1;
        m = '0;
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
                if (ring[(y % RROWS) * MW + x] > m)
                    m = ring[(y % RROWS) * MW + x];
        cnt_out++;
        e.mx = m;
        e.lst = (cnt_out == w * h);
        expected_max.push_back(e);
        if (cnt_out == w * h) begin
            cnt_in = 0;
            cnt_out = 0;
        end
    endtask

    task automatic predict_max(logic func, logic [DW-1:0] pix);
        int unsigned w, h, r, total, idx;
        w = clampu(reg_w, 1, smf_pkg::MAX_WIDTH);
        h = clampu(reg_h, 1, smf_pkg::MAX_HEIGHT);
        r = clampu(reg_r, 1, smf_pkg::MAX_RADIUS);
        total = w * h;
        if (func == smf_pkg::FUNC_PIXEL) begin
            if (cnt_in >= total) return;
            idx = cnt_in;
            ring[((idx / w) % RROWS) * MW + (idx % w)] = pix;
            cnt_in++;
            if (cnt_out < total && idx >= cnt_out + pred_delay())
                emit_max(w, h, r);
        end else if (cnt_in >= total && cnt_out < total) begin
            emit_max(w, h, r);
        end
    endtask

    initial forever #1 aclk = ~aclk;

    // idle rates by stage of the run
    function automatic int send_idle();
        return accepted < 200 ? 11 : (accepted < 400 ? 83 : 0);
    endfunction
    function automatic int recv_idle();
        return accepted < 200 ? 83 : (accepted < 400 ? 11 : 0);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle()) begin
                pix_req_t q;
                q = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= q.func;
                s_tdata <= q.pix;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold && ($urandom_range(99) >= recv_idle());
    end

    always @(posedge aclk) begin
        if (aresetn && cfg_we) begin
            case (cfg_addr)
                smf_pkg::CFG_FRAME_WIDTH:  reg_w = cfg_wdata & 10'h3FF;
                smf_pkg::CFG_FRAME_HEIGHT: reg_h = cfg_wdata & 10'h3FF;
                smf_pkg::CFG_RADIUS:       reg_r = cfg_wdata & 10'h3F;
                default: ;
            endcase
            if (cfg_addr == smf_pkg::CFG_FRAME_WIDTH ||
                cfg_addr == smf_pkg::CFG_FRAME_HEIGHT ||
                cfg_addr == smf_pkg::CFG_RADIUS) begin
                cnt_in = 0;
                cnt_out = 0;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted++;
            predict_max(s_tuser, s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_max.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output %h last %b", m_tdata, m_tlast);
            end else begin
                max_out_t e;
                e = expected_max.pop_front();
                if (e.mx !== m_tdata || e.lst !== m_tlast) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 e.mx, e.lst, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic cfg_write(logic [1:0] a, logic [CB-1:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
    endtask

    task automatic cfg_frame(logic [CB-1:0] w, logic [CB-1:0] h,
                             logic [CB-1:0] r);
        cfg_write(smf_pkg::CFG_FRAME_WIDTH, w);
        cfg_write(smf_pkg::CFG_FRAME_HEIGHT, h);
        cfg_write(smf_pkg::CFG_RADIUS, r);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_req(logic func, logic [DW-1:0] pix);
        pix_req_t q;
        q.func = func;
        q.pix = pix;
        pending_reqs.push_back(q);
        pushed++;
    endtask

    function automatic logic [DW-1:0] rand_pix();
        int k;
        k = $urandom_range(9);
        return k == 0 ? '0 : (k == 1 ? '1 : DW'($urandom));
    endfunction

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_max.size() == 0);
        repeat (300) @(posedge aclk);
    endtask

    // push a whole frame with noise drains, sometimes one extra pixel, then the drains that release it
    task automatic push_frame(int unsigned n_pix);
        int unsigned drains;
        for (int unsigned i = 0; i < n_pix; i++) begin
            if ($urandom_range(19) == 0) push_req(smf_pkg::FUNC_DRAIN, DW'($urandom));
            push_req(smf_pkg::FUNC_PIXEL, rand_pix());
        end
        if ($urandom_range(3) == 0) push_req(smf_pkg::FUNC_PIXEL, rand_pix());
        drains = pred_delay() + $urandom_range(2);
        for (int unsigned i = 0; i < drains; i++)
            push_req(smf_pkg::FUNC_DRAIN, DW'($urandom));
    endtask

    initial begin
        int unsigned w, h;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 4x3, r=1, drain early, extremes, overfill, empty drains
        cfg_frame(10'd4, 10'd3, 10'd1);
        push_req(smf_pkg::FUNC_DRAIN, 16'hFFFF);
        push_req(smf_pkg::FUNC_PIXEL, 16'h0000);
        push_req(smf_pkg::FUNC_PIXEL, 16'hFFFF);
        push_req(smf_pkg::FUNC_PIXEL, 16'h0001);
        push_req(smf_pkg::FUNC_PIXEL, 16'h8000);
        for (int i = 0; i < 8; i++) push_req(smf_pkg::FUNC_PIXEL, 16'h5555 << (i & 1));
        push_req(smf_pkg::FUNC_PIXEL, 16'hFFFF);
        for (int i = 0; i < 6; i++) push_req(smf_pkg::FUNC_DRAIN, 16'h0000);
        wait_idle();

        // new frame mid-way, then clamped extremes
        cfg_frame(10'd5, 10'd5, 10'd2);
        for (int i = 0; i < 6; i++) push_req(smf_pkg::FUNC_PIXEL, rand_pix());
        wait_idle();
        cfg_frame(10'd0, 10'd0, 10'd0);
        push_frame(1);
        wait_idle();
        cfg_frame(10'h3FF, 10'd1, 10'h3FF);
        for (int i = 0; i < 150; i++) push_req(smf_pkg::FUNC_PIXEL, rand_pix());
        wait_idle();
        cfg_frame(10'd1, 10'h3FF, 10'd32);
        for (int i = 0; i < 40; i++) push_req(smf_pkg::FUNC_PIXEL, rand_pix());
        wait_idle();
        cfg_frame(10'd3, 10'd4, 10'd33);
        push_frame(12);
        wait_idle();

        while (pushed < 530) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            cfg_frame(CB'(w), CB'(h),
                      $urandom_range(3) == 0 ? CB'($urandom) : CB'($urandom_range(0, 9)));
            push_frame(w * h);
            wait_idle();
        end

        wait_idle();
        if (errors == 0 && expected_max.size() == 0)
            $display("tb_separable_max_filter_2d_core: clean");
        else
            $display("tb_separable_max_filter_2d_core: errors");
        $finish;
    end

    // long receiver hold-off so the block backs up its input
    initial begin
        wait (accepted >= 300);
        @(posedge aclk);
        hold <= 1'b1;
        repeat (3000) @(posedge aclk);
        hold <= 1'b0;
    end

    initial begin
        #40000000;
        $display("tb_separable_max_filter_2d_core: errors");
        $finish;
    end
endmodule

// ----- files.f -----
design/smf_pkg.sv
design/smf_ram.sv
design/smf_cfg.sv
design/smf_engine.sv
design/separable_max_filter_2d_core.sv
test/tb_separable_max_filter_2d_core.sv
